// File: sv/pts_pkg.sv
// Shared constants, types and keyword table of the Pascal token scanner.
package pts_pkg;

  localparam int MAX_TEXT = 32;
  localparam int TLEN_W   = $clog2(MAX_TEXT + 1);
  localparam int TIX_W    = $clog2(MAX_TEXT);
  localparam int NUM_KW   = 45;
  localparam int KW_MAX   = 14;

  // result kinds
  localparam logic [1:0] KIND_TOKEN  = 2'd0;
  localparam logic [1:0] KIND_TEXT   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  // token codes that are not taken from a table
  localparam logic [6:0] CODE_ASSIGN = 7'd45;
  localparam logic [6:0] CODE_LE     = 7'd46;
  localparam logic [6:0] CODE_GE     = 7'd47;
  localparam logic [6:0] CODE_NE     = 7'd48;
  localparam logic [6:0] CODE_DOTDOT = 7'd49;
  localparam logic [6:0] CODE_IDENT  = 7'd67;
  localparam logic [6:0] CODE_STRING = 7'd68;
  localparam logic [6:0] CODE_NUMBER = 7'd69;
  localparam logic [6:0] CODE_NONE   = 7'd0;

  // error codes
  localparam logic [2:0] ERR_BAD_HEX  = 3'd0;
  localparam logic [2:0] ERR_OPEN_STR = 3'd1;
  localparam logic [2:0] ERR_NL_STR   = 3'd2;
  localparam logic [2:0] ERR_STRAY    = 3'd3;
  localparam logic [2:0] ERR_OPEN_CMT = 3'd4;
  localparam logic [2:0] ERR_REAL     = 3'd5;
  localparam logic [2:0] ERR_TOO_LONG = 3'd6;
  localparam logic [2:0] ERR_NONE     = 3'd0;

  // one command from the scanner; text=1 means text bytes follow (num = length)
  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  code;
    logic [63:0] num;
    logic [15:0] col;
    logic [2:0]  err;
    logic        text;
  } cmd_t;

  // queue entry: up to two commands caused by one transaction
  typedef struct packed {
    logic [1:0]  vld;
    logic [15:0] line;
    cmd_t        c1;
    cmd_t        c0;
  } ent_t;

  // keyword spelling, right aligned, zero padded
  function automatic logic [8*KW_MAX-1:0] kw_word(input int k);
    case (k)
      0:  kw_word = "begin";
      1:  kw_word = "end";
      2:  kw_word = "program";
      3:  kw_word = "unit";
      4:  kw_word = "interface";
      5:  kw_word = "implementation";
      6:  kw_word = "procedure";
      7:  kw_word = "var";
      8:  kw_word = "const";
      9:  kw_word = "type";
      10: kw_word = "function";
      11: kw_word = "string";
      12: kw_word = "boolean";
      13: kw_word = "integer";
      14: kw_word = "pointer";
      15: kw_word = "char";
      16: kw_word = "float";
      17: kw_word = "text";
      18: kw_word = "file";
      19: kw_word = "record";
      20: kw_word = "array";
      21: kw_word = "set";
      22: kw_word = "of";
      23: kw_word = "if";
      24: kw_word = "case";
      25: kw_word = "else";
      26: kw_word = "then";
      27: kw_word = "for";
      28: kw_word = "while";
      29: kw_word = "do";
      30: kw_word = "repeat";
      31: kw_word = "until";
      32: kw_word = "to";
      33: kw_word = "downto";
      34: kw_word = "with";
      35: kw_word = "and";
      36: kw_word = "or";
      37: kw_word = "not";
      38: kw_word = "in";
      39: kw_word = "as";
      40: kw_word = "shl";
      41: kw_word = "shr";
      42: kw_word = "div";
      43: kw_word = "mod";
      44: kw_word = "uses";
      default: kw_word = '0;
    endcase
  endfunction

  function automatic int kw_len(input int k);
    logic [8*KW_MAX-1:0] w;
    int n;
    w = kw_word(k);
    n = 0;
    for (int i = 0; i < KW_MAX; i++) begin
      if (w[8*i +: 8] != 8'd0) n++;
    end
    return n;
  endfunction

  // character i of keyword k, zero past its end
  function automatic logic [7:0] kw_char(input int k, input int i);
    logic [8*KW_MAX-1:0] w;
    int l;
    w = kw_word(k);
    l = kw_len(k);
    if (i >= l) return 8'd0;
    return w[8*(l-1-i) +: 8];
  endfunction

endpackage

// File: sv/pts_if.sv
// Valid/ready channel interfaces for source bytes and scanner results.
interface pts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       end_mark;

  modport source (output valid, output src_byte, output end_mark, input ready);
  modport sink   (input valid, input src_byte, input end_mark, output ready);
endinterface

interface pts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [6:0]  token_code;
  logic [63:0] number_value;
  logic [7:0]  text_byte;
  logic [15:0] line_no;
  logic [15:0] column_no;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output result_kind, output token_code,
                  output number_value, output text_byte, output line_no,
                  output column_no, output error_code, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input token_code,
                  input number_value, input text_byte, input line_no,
                  input column_no, input error_code, input last_of_run,
                  output ready);
endinterface

// File: sv/pascal_token_scanner_unit.sv
// Pascal token scanner top level: front end, command queue and back end.
//
// src_i takes one source byte (or an end marker) per transaction; res_o gives
// token, text byte, error and finished results, the final result of each input
// transaction flagged in last_of_run. Both channels are valid/ready.
// The front end accepts a byte every cycle while it has no token text in
// flight and the two-entry queue has room; each byte yields zero, one or two
// queue commands. The first result of a byte goes from the queue through the
// back end's entry register into the res_o output register; the back end
// gives one result per cycle within an entry while the receiver is ready,
// and takes the next entry from the queue only after the last result of the
// current one has been given.
// After an identifier or string token, input holds until the back end has
// read the token's text out of the buffer.
// Reset returns to the scan start: line 1, column 1, no held token, no error,
// queue and output register empty. A stalled receiver holds the output
// register; the queue then fills and src_i.ready drops.
module pascal_token_scanner_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pts_in_if.sink    src_i,
  pts_out_if.source res_o
);

  pts_pkg::ent_t             push_ent, pop_ent;
  logic                      push, pop, full, empty, text_done;
  logic [pts_pkg::TIX_W-1:0] rd_idx;
  logic [7:0]                rd_data;

  pts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_i       (src_i),
    .push_ent_o  (push_ent),
    .push_o      (push),
    .full_i      (full),
    .text_done_i (text_done),
    .rd_idx_i    (rd_idx),
    .rd_data_o   (rd_data)
  );

  pts_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .pop_i      (pop),
    .pop_ent_o  (pop_ent),
    .full_o     (full),
    .empty_o    (empty)
  );

  pts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_i       (pop_ent),
    .empty_i     (empty),
    .pop_o       (pop),
    .res_o       (res_o),
    .text_done_o (text_done),
    .rd_idx_o    (rd_idx),
    .rd_data_i   (rd_data)
  );

endmodule

// File: sv/pts_front.sv
// Scanner front end: per-byte classification, token state and text buffer.
module pts_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pts_in_if.sink                    src_i,
  output pts_pkg::ent_t             push_ent_o,
  output logic                      push_o,
  input  logic                      full_i,
  input  logic                      text_done_i,
  input  logic [pts_pkg::TIX_W-1:0] rd_idx_i,
  output logic [7:0]                rd_data_o
);

  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_IDENT  = 4'd1;
  localparam logic [3:0] M_DEC    = 4'd2;
  localparam logic [3:0] M_HEX0   = 4'd3;
  localparam logic [3:0] M_HEX    = 4'd4;
  localparam logic [3:0] M_NUMDOT = 4'd5;
  localparam logic [3:0] M_STRING = 4'd6;
  localparam logic [3:0] M_BRACE  = 4'd7;
  localparam logic [3:0] M_PAREN  = 4'd8;
  localparam logic [3:0] M_PSTAR  = 4'd9;
  localparam logic [3:0] M_OPPEND = 4'd10;

  function automatic pts_pkg::cmd_t mk_cmd(input logic [1:0] kind, input logic [6:0] code,
                                           input logic [63:0] num, input logic [15:0] col,
                                           input logic [2:0] err, input logic text);
    pts_pkg::cmd_t r;
    r.kind = kind;
    r.code = code;
    r.num  = num;
    r.col  = col;
    r.err  = err;
    r.text = text;
    return r;
  endfunction

  // bit 7 set when the byte is a one-character operator
  function automatic logic [7:0] single_op(input logic [7:0] ch);
    case (ch)
      "+":     single_op = {1'b1, 7'd50};
      "-":     single_op = {1'b1, 7'd51};
      "/":     single_op = {1'b1, 7'd52};
      "*":     single_op = {1'b1, 7'd53};
      "<":     single_op = {1'b1, 7'd54};
      ">":     single_op = {1'b1, 7'd55};
      "(":     single_op = {1'b1, 7'd56};
      ")":     single_op = {1'b1, 7'd57};
      "[":     single_op = {1'b1, 7'd58};
      "]":     single_op = {1'b1, 7'd59};
      "=":     single_op = {1'b1, 7'd60};
      ",":     single_op = {1'b1, 7'd61};
      ":":     single_op = {1'b1, 7'd62};
      ".":     single_op = {1'b1, 7'd63};
      ";":     single_op = {1'b1, 7'd64};
      "@":     single_op = {1'b1, 7'd65};
      "^":     single_op = {1'b1, 7'd66};
      default: single_op = 8'd0;
    endcase
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // state
  logic [3:0]                    mode_q, mode_d;
  logic [pts_pkg::TLEN_W-1:0]    len_q, len_d;
  logic [63:0]                   acc_q, acc_d;
  logic [7:0]                    pend_q, pend_d;
  logic [15:0]                   line_q, line_d;
  logic [15:0]                   col_q, col_d;
  logic [15:0]                   tcol_q, tcol_d;
  logic [15:0]                   dot_q, dot_d;
  logic                          err_q, err_d;
  logic [pts_pkg::NUM_KW-1:0]    kwm_q, kwm_d;
  logic                          tbusy_q;
  logic [7:0]                    buf_q [pts_pkg::MAX_TEXT];

  // per-byte working signals
  logic [7:0]                    ch, lc, sop, pend_sop;
  logic                          is_dig, is_alp, is_hex, take;
  logic [3:0]                    hexv;
  logic [pts_pkg::NUM_KW-1:0]    kwm_init, kwm_app;
  logic                          kw_hit;
  logic [6:0]                    kw_idx;
  pts_pkg::cmd_t                 fin_cmd, num_cmd, pend_cmd;
  pts_pkg::cmd_t                 cq [2];
  logic [1:0]                    n_v;
  logic                          go_idle;
  logic                          buf_we;
  logic [pts_pkg::TIX_W-1:0]     buf_wa;

  assign ch   = src_i.src_byte;
  assign take = src_i.valid && src_i.ready;
  assign src_i.ready = !full_i && !tbusy_q;
  assign rd_data_o   = buf_q[rd_idx_i];
  assign pend_sop    = single_op(pend_q);

  // byte classes
  always_comb begin
    is_dig = (ch >= "0") && (ch <= "9");
    is_alp = (ch == "_") || ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    lc     = ((ch >= "A") && (ch <= "Z")) ? ch + 8'd32 : ch;
    is_hex = 1'b1;
    hexv   = 4'd0;
    if (is_dig) hexv = ch[3:0];
    else if ((lc >= "a") && (lc <= "f")) hexv = 4'(lc - 8'd87);
    else is_hex = 1'b0;
    sop = single_op(ch);
  end

  // keyword candidate tracking, one character position per byte
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 7'd0;
    for (int k = 0; k < pts_pkg::NUM_KW; k++) begin
      kwm_init[k] = (pts_pkg::kw_char(k, 0) == lc);
      kwm_app[k]  = kwm_q[k] && (pts_pkg::kw_char(k, int'(len_q)) == lc);
      if (kwm_q[k] && (pts_pkg::kw_len(k) == int'(len_q))) begin
        kw_hit = 1'b1;
        kw_idx = 7'(k);
      end
    end
  end

  // commands that finish a held token
  always_comb begin
    fin_cmd = kw_hit
      ? mk_cmd(pts_pkg::KIND_TOKEN, kw_idx, 64'd0, tcol_q, pts_pkg::ERR_NONE, 1'b0)
      : mk_cmd(pts_pkg::KIND_TOKEN, pts_pkg::CODE_IDENT, 64'(len_q), tcol_q,
               pts_pkg::ERR_NONE, 1'b1);
    num_cmd  = mk_cmd(pts_pkg::KIND_TOKEN, pts_pkg::CODE_NUMBER, acc_q, tcol_q,
                      pts_pkg::ERR_NONE, 1'b0);
    pend_cmd = mk_cmd(pts_pkg::KIND_TOKEN, pend_sop[6:0], 64'd0, tcol_q,
                      pts_pkg::ERR_NONE, 1'b0);
  end

  // next state and commands for one transaction
  always_comb begin
    mode_d = mode_q;  len_d = len_q;   acc_d = acc_q;  pend_d = pend_q;
    line_d = line_q;  col_d = col_q;   tcol_d = tcol_q; dot_d = dot_q;
    err_d  = err_q;   kwm_d = kwm_q;
    buf_we = 1'b0;
    buf_wa = len_q[pts_pkg::TIX_W-1:0];
    cq[0]  = '0;
    cq[1]  = '0;
    n_v    = 2'd0;
    go_idle = 1'b0;

    if (src_i.end_mark) begin
      // flush the held token
      if (!err_q) begin
        case (mode_q)
          M_IDENT: begin
            cq[n_v[0]] = fin_cmd; n_v = n_v + 2'd1;
          end
          M_DEC, M_HEX: begin
            cq[n_v[0]] = num_cmd; n_v = n_v + 2'd1;
          end
          M_HEX0: begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_ERROR, pts_pkg::CODE_NONE, 64'd0, tcol_q,
                                pts_pkg::ERR_BAD_HEX, 1'b0);
            n_v = n_v + 2'd1;
          end
          M_NUMDOT: begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_ERROR, pts_pkg::CODE_NONE, 64'd0, tcol_q,
                                pts_pkg::ERR_REAL, 1'b0);
            n_v = n_v + 2'd1;
          end
          M_STRING: begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_ERROR, pts_pkg::CODE_NONE, 64'd0, tcol_q,
                                pts_pkg::ERR_OPEN_STR, 1'b0);
            n_v = n_v + 2'd1;
          end
          M_BRACE, M_PAREN, M_PSTAR: begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_ERROR, pts_pkg::CODE_NONE, 64'd0, col_q,
                                pts_pkg::ERR_OPEN_CMT, 1'b0);
            n_v = n_v + 2'd1;
          end
          M_OPPEND: begin
            cq[n_v[0]] = pend_cmd; n_v = n_v + 2'd1;
          end
          default: ;
        endcase
      end
      cq[n_v[0]] = mk_cmd(pts_pkg::KIND_FINISH, pts_pkg::CODE_NONE, 64'd0, col_q,
                          pts_pkg::ERR_NONE, 1'b0);
      n_v = n_v + 2'd1;
      // back to reset values
      mode_d = M_IDLE;  len_d = '0;      acc_d = '0;     pend_d = '0;
      line_d = 16'd1;   col_d = 16'd1;   tcol_d = 16'd1; dot_d = 16'd1;
      err_d  = 1'b0;
    end else if (!err_q) begin
      case (mode_q)
        M_IDENT: begin
          if (is_alp || is_dig) begin
            if (len_q >= pts_pkg::TLEN_W'(pts_pkg::MAX_TEXT)) begin
              cq[n_v[0]] = mk_cmd(pts_pkg::KIND_ERROR, pts_pkg::CODE_NONE, 64'd0, tcol_q,
                                  pts_pkg::ERR_TOO_LONG, 1'b0);
              n_v = n_v + 2'd1; err_d = 1'b1; mode_d = M_IDLE;
            end else begin
              buf_we = 1'b1;
              len_d  = len_q + pts_pkg::TLEN_W'(1);
              kwm_d  = kwm_app;
            end
          end else begin
            cq[n_v[0]] = fin_cmd; n_v = n_v + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_DEC: begin
          if (is_dig) begin
            acc_d = (acc_q << 3) + (acc_q << 1) + 64'(ch[3:0]);
          end else if (ch == ".") begin
            dot_d = col_q; mode_d = M_NUMDOT;
          end else begin
            cq[n_v[0]] = num_cmd; n_v = n_v + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_HEX0, M_HEX: begin
          if (is_hex) begin
            acc_d  = {acc_q[59:0], hexv};
            mode_d = M_HEX;
          end else if (mode_q == M_HEX0) begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_ERROR, pts_pkg::CODE_NONE, 64'd0, tcol_q,
                                pts_pkg::ERR_BAD_HEX, 1'b0);
            n_v = n_v + 2'd1; err_d = 1'b1; mode_d = M_IDLE;
          end else begin
            cq[n_v[0]] = num_cmd; n_v = n_v + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (ch == ".") begin
            cq[n_v[0]] = num_cmd; n_v = n_v + 2'd1;
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_TOKEN, pts_pkg::CODE_DOTDOT, 64'd0, dot_q,
                                pts_pkg::ERR_NONE, 1'b0);
            n_v = n_v + 2'd1;
            mode_d = M_IDLE;
          end else begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_ERROR, pts_pkg::CODE_NONE, 64'd0, tcol_q,
                                pts_pkg::ERR_REAL, 1'b0);
            n_v = n_v + 2'd1; err_d = 1'b1; mode_d = M_IDLE;
          end
        end
        M_STRING: begin
          if (ch == "'") begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_TOKEN, pts_pkg::CODE_STRING, 64'(len_q),
                                tcol_q, pts_pkg::ERR_NONE, 1'b1);
            n_v = n_v + 2'd1; mode_d = M_IDLE;
          end else if (ch == 8'h0A) begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_ERROR, pts_pkg::CODE_NONE, 64'd0, tcol_q,
                                pts_pkg::ERR_NL_STR, 1'b0);
            n_v = n_v + 2'd1; err_d = 1'b1; mode_d = M_IDLE;
          end else if (len_q >= pts_pkg::TLEN_W'(pts_pkg::MAX_TEXT)) begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_ERROR, pts_pkg::CODE_NONE, 64'd0, tcol_q,
                                pts_pkg::ERR_TOO_LONG, 1'b0);
            n_v = n_v + 2'd1; err_d = 1'b1; mode_d = M_IDLE;
          end else begin
            buf_we = 1'b1;
            len_d  = len_q + pts_pkg::TLEN_W'(1);
          end
        end
        M_BRACE: begin
          if (ch == "}") mode_d = M_IDLE;
        end
        M_PAREN: begin
          if (ch == "*") mode_d = M_PSTAR;
        end
        M_PSTAR: begin
          if (ch == ")") mode_d = M_IDLE;
          else if (ch != "*") mode_d = M_PAREN;
        end
        M_OPPEND: begin
          if ((pend_q == "(") && (ch == "*")) begin
            mode_d = M_PAREN;
          end else if ((pend_q == ":") && (ch == "=")) begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_TOKEN, pts_pkg::CODE_ASSIGN, 64'd0, tcol_q,
                                pts_pkg::ERR_NONE, 1'b0);
            n_v = n_v + 2'd1; mode_d = M_IDLE;
          end else if ((pend_q == "<") && (ch == "=")) begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_TOKEN, pts_pkg::CODE_LE, 64'd0, tcol_q,
                                pts_pkg::ERR_NONE, 1'b0);
            n_v = n_v + 2'd1; mode_d = M_IDLE;
          end else if ((pend_q == ">") && (ch == "=")) begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_TOKEN, pts_pkg::CODE_GE, 64'd0, tcol_q,
                                pts_pkg::ERR_NONE, 1'b0);
            n_v = n_v + 2'd1; mode_d = M_IDLE;
          end else if ((pend_q == "<") && (ch == ">")) begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_TOKEN, pts_pkg::CODE_NE, 64'd0, tcol_q,
                                pts_pkg::ERR_NONE, 1'b0);
            n_v = n_v + 2'd1; mode_d = M_IDLE;
          end else if ((pend_q == ".") && (ch == ".")) begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_TOKEN, pts_pkg::CODE_DOTDOT, 64'd0, tcol_q,
                                pts_pkg::ERR_NONE, 1'b0);
            n_v = n_v + 2'd1; mode_d = M_IDLE;
          end else begin
            cq[n_v[0]] = pend_cmd; n_v = n_v + 2'd1;
            go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase

      // start of a new token between tokens
      if (go_idle) begin
        mode_d = M_IDLE;
        if (!((ch == " ") || (ch == 8'h09) || (ch == 8'h0D) || (ch == 8'h0A))) begin
          tcol_d = col_q;
          if (ch == "{") begin
            mode_d = M_BRACE;
          end else if (ch == "$") begin
            acc_d = '0; mode_d = M_HEX0;
          end else if (is_dig) begin
            acc_d = 64'(ch[3:0]); mode_d = M_DEC;
          end else if (is_alp) begin
            buf_we = 1'b1; buf_wa = '0; len_d = pts_pkg::TLEN_W'(1);
            kwm_d = kwm_init; mode_d = M_IDENT;
          end else if (ch == "'") begin
            len_d = '0; mode_d = M_STRING;
          end else if ((ch == "(") || (ch == ":") || (ch == "<") || (ch == ">") ||
                       (ch == ".")) begin
            pend_d = ch; mode_d = M_OPPEND;
          end else if (sop[7]) begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_TOKEN, sop[6:0], 64'd0, col_q,
                                pts_pkg::ERR_NONE, 1'b0);
            n_v = n_v + 2'd1;
          end else begin
            cq[n_v[0]] = mk_cmd(pts_pkg::KIND_ERROR, pts_pkg::CODE_NONE, 64'd0, col_q,
                                pts_pkg::ERR_STRAY, 1'b0);
            n_v = n_v + 2'd1; err_d = 1'b1;
          end
        end
      end

      // position tracking
      if (ch == 8'h0A) begin
        line_d = sat_inc(line_q);
        col_d  = 16'd1;
      end else if ((ch != 8'h0D) || (mode_q == M_STRING)) begin
        col_d = sat_inc(col_q);
      end
    end
  end

  // queue entry
  always_comb begin
    push_ent_o.vld  = {n_v == 2'd2, n_v != 2'd0};
    push_ent_o.line = line_q;
    push_ent_o.c0   = cq[0];
    push_ent_o.c1   = cq[1];
  end
  assign push_o = take && (n_v != 2'd0);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      len_q   <= '0;
      acc_q   <= '0;
      pend_q  <= '0;
      line_q  <= 16'd1;
      col_q   <= 16'd1;
      tcol_q  <= 16'd1;
      dot_q   <= 16'd1;
      err_q   <= 1'b0;
      kwm_q   <= '0;
      tbusy_q <= 1'b0;
    end else begin
      if (take) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        acc_q  <= acc_d;
        pend_q <= pend_d;
        line_q <= line_d;
        col_q  <= col_d;
        tcol_q <= tcol_d;
        dot_q  <= dot_d;
        err_q  <= err_d;
        kwm_q  <= kwm_d;
      end
      // hold input while the back end reads token text out of the buffer
      if (push_o && (cq[0].text || cq[1].text)) tbusy_q <= 1'b1;
      else if (text_done_i) tbusy_q <= 1'b0;
    end
  end

  // text buffer
  always_ff @(posedge clk_i) begin
    if (take && buf_we) buf_q[buf_wa] <= ch;
  end

endmodule

// File: sv/pts_fifo.sv
// Two-entry command queue between scanner front end and result back end.
module pts_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pts_pkg::ent_t  push_ent_i,
  input  logic           pop_i,
  output pts_pkg::ent_t  pop_ent_o,
  output logic           full_o,
  output logic           empty_o
);

  pts_pkg::ent_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign pop_ent_o = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_ent_i;
  end

endmodule

// File: sv/pts_back.sv
// Result back end: expands queued commands into results, with text bytes.
module pts_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pts_pkg::ent_t             ent_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  pts_out_if.source                 res_o,
  output logic                      text_done_o,
  output logic [pts_pkg::TIX_W-1:0] rd_idx_o,
  input  logic [7:0]                rd_data_i
);

  logic                        busy_q;
  logic                        sel_q;
  logic [pts_pkg::TLEN_W-1:0]  tix_q, tix_m1;
  pts_pkg::ent_t               ent_q;
  pts_pkg::cmd_t               cur;
  logic                        cmd_done, last, emit;

  // output register
  logic        ov_q;
  logic [1:0]  kind_q;
  logic [6:0]  code_q;
  logic [63:0] num_q;
  logic [7:0]  byte_q;
  logic [15:0] line_q, col_q;
  logic [2:0]  err_q;
  logic        last_q;

  assign cur      = sel_q ? ent_q.c1 : ent_q.c0;
  assign cmd_done = !cur.text || (tix_q == cur.num[pts_pkg::TLEN_W-1:0]);
  assign last     = cmd_done && (sel_q || !ent_q.vld[1]);
  assign tix_m1   = tix_q - pts_pkg::TLEN_W'(1);
  assign rd_idx_o = tix_m1[pts_pkg::TIX_W-1:0];
  assign emit     = busy_q && (!ov_q || res_o.ready);
  assign pop_o    = !busy_q && !empty_i;
  assign text_done_o = emit && cmd_done && cur.text;

  assign res_o.valid        = ov_q;
  assign res_o.result_kind  = kind_q;
  assign res_o.token_code   = code_q;
  assign res_o.number_value = num_q;
  assign res_o.text_byte    = byte_q;
  assign res_o.line_no      = line_q;
  assign res_o.column_no    = col_q;
  assign res_o.error_code   = err_q;
  assign res_o.last_of_run  = last_q;

  // sequencing through the entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sel_q  <= 1'b0;
      tix_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        sel_q  <= 1'b0;
        tix_q  <= '0;
      end else if (emit) begin
        if (!cmd_done) begin
          tix_q <= tix_q + pts_pkg::TLEN_W'(1);
        end else if (!last) begin
          sel_q <= 1'b1;
          tix_q <= '0;
        end else begin
          busy_q <= 1'b0;
        end
      end
      if (emit) ov_q <= 1'b1;
      else if (res_o.ready) ov_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= ent_i;
    if (emit) begin
      line_q <= ent_q.line;
      col_q  <= cur.col;
      code_q <= cur.code;
      last_q <= last;
      if (tix_q == '0) begin
        kind_q <= cur.kind;
        num_q  <= cur.num;
        byte_q <= 8'd0;
        err_q  <= cur.err;
      end else begin
        kind_q <= pts_pkg::KIND_TEXT;
        num_q  <= 64'd0;
        byte_q <= rd_data_i;
        err_q  <= pts_pkg::ERR_NONE;
      end
    end
  end

endmodule
